// ===== rtl/core/i2c_target_command_buffer_core_defines.svh =====
// Assertion macros used by the command buffer checker.
`ifndef I2C_TARGET_COMMAND_BUFFER_CORE_DEFINES_SVH
`define I2C_TARGET_COMMAND_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CTCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define I2CTCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/i2ctcb_pkg.sv =====
// Package: types, codes and sizes of the I2C target command buffer.
`timescale 1ns / 1ps
`default_nettype none
package i2ctcb_pkg;

    // Buffer and command table sizes
    localparam int BUF_BYTES = 16;
    localparam int MAX_CMDS  = 4;
    localparam int NUM_CODES = 4;
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);
    localparam int IDX_W     = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int USED_W    = 3;
    localparam int CMD_IDX_W = 2;
    localparam int DLEN_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 8;

    // Event kinds
    localparam logic [2:0] KIND_ADDR  = 3'd0;
    localparam logic [2:0] KIND_STOP  = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;

    // Response codes
    localparam logic [1:0] RESP_ACK      = 2'd0;
    localparam logic [1:0] RESP_NACK     = 2'd1;
    localparam logic [1:0] RESP_COMPLETE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_CODE_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_CODE_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_CODE_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_CODE_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 3'd4;

    typedef logic [NUM_CODES-1:0][7:0] code_table_t;

    // Command table lookup result
    typedef struct packed {
        logic                 hit;
        logic [CMD_IDX_W-1:0] index;
    } match_t;

    // One input event item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       master_nack;
    } event_t;

    // One result item
    typedef struct packed {
        logic [1:0]           response;
        logic                 released;
        logic                 read_valid;
        logic [7:0]           read_byte;
        logic                 dispatch;
        logic [CMD_IDX_W-1:0] dispatch_index;
        logic [DLEN_W-1:0]    dispatch_length;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/i2ctcb_if.sv =====
// Interfaces: event input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface i2ctcb_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       master_nack;

    modport source (output valid, kind, data_byte, master_nack, input ready);
    modport sink   (input valid, kind, data_byte, master_nack, output ready);
endinterface

interface i2ctcb_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] response;
    logic       released;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       dispatch;
    logic [1:0] dispatch_index;
    logic [4:0] dispatch_length;

    modport source (output valid, response, released, read_valid, read_byte,
                    dispatch, dispatch_index, dispatch_length, input ready);
    modport sink   (input valid, response, released, read_valid, read_byte,
                    dispatch, dispatch_index, dispatch_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/i2ctcb_cmd_match.sv =====
// Command table match: parallel compare of the first byte against the codes.
`timescale 1ns / 1ps
`default_nettype none
module i2ctcb_cmd_match
    import i2ctcb_pkg::*;
(
    input  code_table_t       codes,
    input  logic [USED_W-1:0] entries_used,
    input  logic [7:0]        data_byte,
    output match_t            result
);

    logic [USED_W-1:0] used;

    // Entries beyond the table saturate to its size
    assign used = (entries_used > USED_W'(MAX_CMDS)) ? USED_W'(MAX_CMDS) : entries_used;

    // Lowest matching entry wins: scan from the top so it is assigned last
    always_comb
    begin
        result = '0;
        for (int i = MAX_CMDS - 1; i >= 0; i--)
        begin
            if ((USED_W'(i) < used) && (codes[i] == data_byte))
            begin
                result.hit   = 1'b1;
                result.index = CMD_IDX_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/i2ctcb_byte_buf.sv =====
// Byte buffer: one write port and one read port, cleared at reset.
`timescale 1ns / 1ps
`default_nettype none
module i2ctcb_byte_buf
    import i2ctcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] store_reg [BUF_BYTES];

    // Storage, zeroed by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUF_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = store_reg[rd_addr];

endmodule
`default_nettype wire

// ===== rtl/core/i2c_target_command_buffer_core.sv =====
// Top level: I2C target command buffer with event and result channels.
// The block takes one decoded I2C bus event per item and returns one result
// item for each. It accepts a new item every cycle while the result channel
// does not stall; each item passes through the input register, then the
// result register, and a stalled result register holds back at most one more
// item in the input register. Written bytes fill a 16-byte buffer; the first
// byte of a write is compared in parallel against up to four configured
// command codes, and stop or a repeated address match while busy dispatches
// the matched command with the byte count. Reads return buffer bytes in
// order. Configuration writes (codes 0..3, entries used at index 4) are taken
// at once and must be done only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module i2c_target_command_buffer_core
    import i2ctcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    i2ctcb_event_if.sink         evt,
    i2ctcb_result_if.source      res
);

    // Configuration
    code_table_t       codes_reg;
    logic [USED_W-1:0] used_reg;

    // Transaction state
    logic [CNT_W-1:0]     wcount_reg, wcount_next;
    logic [CNT_W-1:0]     rptr_reg, rptr_next;
    logic                 busy_reg, busy_next;
    logic                 mvalid_reg, mvalid_next;
    logic [CMD_IDX_W-1:0] midx_reg, midx_next;

    // Pipeline
    logic    in_valid_reg;
    event_t  in_reg;
    logic    out_valid_reg;
    result_t out_reg, out_next;
    logic    advance;

    // Buffer and match
    logic       buf_wr;
    logic [7:0] buf_rd_data;
    match_t     match;
    logic       full;
    logic       read_done;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg <= '0;
            used_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CMD_CODE_0:   codes_reg[0] <= cfg_data;
                CFG_CMD_CODE_1:   codes_reg[1] <= cfg_data;
                CFG_CMD_CODE_2:   codes_reg[2] <= cfg_data;
                CFG_CMD_CODE_3:   codes_reg[3] <= cfg_data;
                CFG_ENTRIES_USED: used_reg     <= cfg_data[USED_W-1:0];
                default:          ;
            endcase
        end
    end

    // Handshake: input register moves on when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            in_reg.kind        <= evt.kind;
            in_reg.data_byte   <= evt.data_byte;
            in_reg.master_nack <= evt.master_nack;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    i2ctcb_cmd_match u_cmd_match (
        .codes        (codes_reg),
        .entries_used (used_reg),
        .data_byte    (in_reg.data_byte),
        .result       (match)
    );

    i2ctcb_byte_buf u_byte_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (buf_wr),
        .wr_addr (wcount_reg[IDX_W-1:0]),
        .wr_data (in_reg.data_byte),
        .rd_addr (rptr_reg[IDX_W-1:0]),
        .rd_data (buf_rd_data)
    );

    assign full      = wcount_reg >= CNT_W'(BUF_BYTES);
    assign read_done = ((rptr_reg != '0) && in_reg.master_nack) ||
                       (rptr_reg >= CNT_W'(BUF_BYTES));

    // Event processing
    always_comb
    begin
        wcount_next = wcount_reg;
        rptr_next   = rptr_reg;
        busy_next   = busy_reg;
        mvalid_next = mvalid_reg;
        midx_next   = midx_reg;
        buf_wr      = 1'b0;
        out_next    = '0;

        case (in_reg.kind)
            KIND_STOP:
            begin
                if (mvalid_reg)
                begin
                    out_next.dispatch        = 1'b1;
                    out_next.dispatch_index  = midx_reg;
                    out_next.dispatch_length = DLEN_W'(wcount_reg);
                    mvalid_next              = 1'b0;
                end
                out_next.response = RESP_COMPLETE;
                out_next.released = 1'b1;
                busy_next         = 1'b0;
            end
            KIND_ADDR:
            begin
                // Repeated start while busy dispatches the pending command
                if (busy_reg && mvalid_reg)
                begin
                    out_next.dispatch        = 1'b1;
                    out_next.dispatch_index  = midx_reg;
                    out_next.dispatch_length = DLEN_W'(wcount_reg);
                end
                busy_next         = 1'b1;
                wcount_next       = '0;
                rptr_next         = '0;
                mvalid_next       = 1'b0;
                out_next.response = RESP_ACK;
            end
            KIND_WRITE:
            begin
                if (full)
                begin
                    out_next.response = RESP_NACK;
                end
                else
                begin
                    // Store the byte only in the cycle the item is processed
                    buf_wr      = advance;
                    wcount_next = wcount_reg + CNT_W'(1);
                    // First byte selects the command; no hit keeps the old match
                    if ((wcount_reg == '0) && match.hit)
                    begin
                        mvalid_next = 1'b1;
                        midx_next   = match.index;
                    end
                    out_next.response = mvalid_next ? RESP_ACK : RESP_NACK;
                end
            end
            KIND_READ:
            begin
                if (read_done)
                begin
                    out_next.response = RESP_COMPLETE;
                end
                else
                begin
                    out_next.read_valid = 1'b1;
                    out_next.read_byte  = buf_rd_data;
                    rptr_next           = rptr_reg + CNT_W'(1);
                    out_next.response   = RESP_ACK;
                end
            end
            default:
            begin
                // Bus error, other and unused kinds: release, keep the match
                out_next.response = RESP_COMPLETE;
                out_next.released = 1'b1;
                busy_next         = 1'b0;
            end
        endcase
    end

    // State update, once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcount_reg <= '0;
            rptr_reg   <= '0;
            busy_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            midx_reg   <= '0;
        end
        else if (advance)
        begin
            wcount_reg <= wcount_next;
            rptr_reg   <= rptr_next;
            busy_reg   <= busy_next;
            mvalid_reg <= mvalid_next;
            midx_reg   <= midx_next;
        end
    end

    // Result channel
    assign res.valid           = out_valid_reg;
    assign res.response        = out_reg.response;
    assign res.released        = out_reg.released;
    assign res.read_valid      = out_reg.read_valid;
    assign res.read_byte       = out_reg.read_byte;
    assign res.dispatch        = out_reg.dispatch;
    assign res.dispatch_index  = out_reg.dispatch_index;
    assign res.dispatch_length = out_reg.dispatch_length;

endmodule
`default_nettype wire

// ===== rtl/core/i2ctcb_checker.sv =====
// Checker: port-level assertions on the command buffer result channel.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_target_command_buffer_core_defines.svh"
module i2ctcb_checker
    import i2ctcb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] response,
    input wire logic       released,
    input wire logic       read_valid,
    input wire logic [7:0] read_byte,
    input wire logic       dispatch,
    input wire logic [1:0] dispatch_index,
    input wire logic [4:0] dispatch_length
);

    // A stalled result holds
    `I2CTCB_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({response, released, read_valid, read_byte, dispatch, dispatch_index, dispatch_length}), "result changed while stalled")

    // A byte to send comes only with an acknowledge and no release or dispatch
    `I2CTCB_ASSERT_NOW(a_read_ack, clk, rst_n, res_valid && read_valid, (response == RESP_ACK) && !released && !dispatch, "read byte with wrong response")

    // Release only ends a transaction with complete
    `I2CTCB_ASSERT_NOW(a_release_complete, clk, rst_n, res_valid && released, (response == RESP_COMPLETE) && !read_valid, "release without complete")

    // Dispatch fields are zero when nothing is dispatched
    `I2CTCB_ASSERT_NOW(a_dispatch_idle, clk, rst_n, res_valid && !dispatch, (dispatch_index == '0) && (dispatch_length == '0), "dispatch fields set without dispatch")

endmodule

bind i2c_target_command_buffer_core i2ctcb_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .response        (res.response),
    .released        (res.released),
    .read_valid      (res.read_valid),
    .read_byte       (res.read_byte),
    .dispatch        (res.dispatch),
    .dispatch_index  (res.dispatch_index),
    .dispatch_length (res.dispatch_length)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the I2C target command buffer core.
`timescale 1ns / 1ps
module tb;
    import i2ctcb_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int RAND_PER_PHASE = 112;
    localparam int NUM_PHASES     = 7;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    // Kind codes the block does not name; it treats them as "other"
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam result_t NO_RESULT = '0;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

    // One row of the directed stimulus table
    typedef struct {
        event_t  ev;
        int      reps;
        bit      known;
        result_t want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    i2ctcb_event_if  evt_ch();
    i2ctcb_result_if res_ch();

    i2c_target_command_buffer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_ch),
        .res       (res_ch)
    );

    // Shadow of the command table and transaction state
    logic [7:0]           cmd_codes [NUM_CODES];
    logic [USED_W-1:0]    entries_used;
    logic [7:0]           buf_mem [BUF_BYTES];
    logic [CNT_W-1:0]     byte_cnt;
    logic [CNT_W-1:0]     rd_ptr;
    logic                 bus_busy;
    logic                 cmd_matched;
    logic [CMD_IDX_W-1:0] cmd_idx;

    result_t   expected_results[$];
    stim_row_t directed_rows[$];
    int        items_sent;
    int        mismatches;
    int        burst_left;
    bit        hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic result_t outcome(input logic [1:0] resp, input logic rel,
                                        input logic rv, input logic [7:0] rb,
                                        input logic disp, input logic [1:0] didx,
                                        input logic [4:0] dlen);
        return {resp, rel, rv, rb, disp, didx, dlen};
    endfunction

    function automatic event_t bus_event(input logic [2:0] kind, input logic [7:0] data,
                                         input logic nack);
        return {kind, data, nack};
    endfunction

    // Next result of the engine for one bus event; updates the shadow state
    function automatic result_t predict_bus_event(input event_t e);
        result_t r;
        int      n_used;
        int      i;
        bit      found;
        r = '0;
        case (e.kind)
            KIND_STOP:
            begin
                if (cmd_matched)
                begin
                    r.dispatch        = 1'b1;
                    r.dispatch_index  = cmd_idx;
                    r.dispatch_length = byte_cnt;
                    cmd_matched       = 1'b0;
                end
                r.response = RESP_COMPLETE;
                r.released = 1'b1;
                bus_busy   = 1'b0;
            end
            KIND_ADDR:
            begin
                // restart while busy hands the pending command over
                if (bus_busy && cmd_matched)
                begin
                    r.dispatch        = 1'b1;
                    r.dispatch_index  = cmd_idx;
                    r.dispatch_length = byte_cnt;
                end
                bus_busy    = 1'b1;
                byte_cnt    = '0;
                rd_ptr      = '0;
                cmd_matched = 1'b0;
                r.response  = RESP_ACK;
            end
            KIND_WRITE:
            begin
                if (byte_cnt >= BUF_BYTES)
                begin
                    r.response = RESP_NACK;
                end
                else
                begin
                    buf_mem[byte_cnt[IDX_W-1:0]] = e.data_byte;
                    byte_cnt++;
                    // first byte looks up the table, lowest entry wins
                    if (byte_cnt == 1)
                    begin
                        n_used = (entries_used > MAX_CMDS) ? MAX_CMDS : int'(entries_used);
                        found  = 1'b0;
                        for (i = 0; i < n_used; i++)
                        begin
                            if (!found && cmd_codes[i] == buf_mem[0])
                            begin
                                found       = 1'b1;
                                cmd_matched = 1'b1;
                                cmd_idx     = CMD_IDX_W'(i);
                            end
                        end
                    end
                    r.response = cmd_matched ? RESP_ACK : RESP_NACK;
                end
            end
            KIND_READ:
            begin
                if ((rd_ptr != 0 && e.master_nack) || rd_ptr >= BUF_BYTES)
                begin
                    r.response = RESP_COMPLETE;
                end
                else
                begin
                    r.read_valid = 1'b1;
                    r.read_byte  = buf_mem[rd_ptr[IDX_W-1:0]];
                    rd_ptr++;
                    r.response   = RESP_ACK;
                end
            end
            default:
            begin
                // bus error, other and spare codes: release, keep the match
                r.response = RESP_COMPLETE;
                r.released = 1'b1;
                bus_busy   = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input result_t want,
                                   input result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected resp=%0d rel=%0d rv=%0d rb=%02h disp=%0d idx=%0d len=%0d",
                     $time, what, want.response, want.released, want.read_valid,
                     want.read_byte, want.dispatch, want.dispatch_index,
                     want.dispatch_length);
            $display("    actual   resp=%0d rel=%0d rv=%0d rb=%02h disp=%0d idx=%0d len=%0d",
                     got.response, got.released, got.read_valid, got.read_byte,
                     got.dispatch, got.dispatch_index, got.dispatch_length);
        end
    endtask

    // Register write, one per clock edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_ENTRIES_USED)
            entries_used = val[USED_W-1:0];
        else
            cmd_codes[idx[1:0]] = val;
    endtask

    task automatic load_table(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic [7:0] c3,
                              input logic [USED_W-1:0] used);
        write_reg(CFG_CMD_CODE_0, c0);
        write_reg(CFG_CMD_CODE_1, c1);
        write_reg(CFG_CMD_CODE_2, c2);
        write_reg(CFG_CMD_CODE_3, c3);
        write_reg(CFG_ENTRIES_USED, CFG_W'(used));
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one event item in bursts with random gaps; queue its expected result
    task automatic send_event(input event_t e, input bit known = 1'b0,
                              input result_t want = '0);
        result_t predicted;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                evt_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        evt_ch.valid       <= 1'b1;
        evt_ch.kind        <= e.kind;
        evt_ch.data_byte   <= e.data_byte;
        evt_ch.master_nack <= e.master_nack;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        predicted = predict_bus_event(e);
        expected_results.push_back(known ? want : predicted);
        items_sent++;
        burst_left--;
    endtask

    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] kind, input logic [7:0] data,
                           input logic nack, input int reps, input bit known,
                           input result_t want);
        stim_row_t row;
        row.ev    = bus_event(kind, data, nack);
        row.reps  = reps;
        row.known = known;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Random transactions: mostly well-formed writes and reads, some noise
    task automatic run_random(input int quota);
        int         first_item;
        int         pick;
        int         n;
        int         i;
        bit         do_read;
        logic [7:0] first_byte;
        first_item = items_sent;
        while (items_sent - first_item < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_event(bus_event(KIND_ADDR, 8'($urandom), 1'($urandom)));
                do_read = (pick >= 55) || ($urandom_range(0, 1) == 1);
                if (pick < 55)
                begin
                    // first byte usually hits a table entry
                    first_byte = ($urandom_range(0, 3) != 0) ?
                                 cmd_codes[$urandom_range(0, 3)] : 8'($urandom);
                    send_event(bus_event(KIND_WRITE, first_byte, 1'($urandom)));
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
                                                    : $urandom_range(0, 5);
                    for (i = 0; i < n; i++)
                        send_event(bus_event(KIND_WRITE, 8'($urandom), 1'($urandom)));
                    if (do_read)
                        send_event(bus_event(KIND_ADDR, 8'($urandom), 1'($urandom)));
                end
                if (do_read)
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18)
                                                    : $urandom_range(1, 4);
                    for (i = 0; i < n; i++)
                        send_event(bus_event(KIND_READ, 8'($urandom),
                                             (i == n - 1) ? 1'($urandom)
                                                          : ($urandom_range(0, 15) == 0)));
                end
                // close: mostly stop, sometimes error or other, sometimes nothing
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    send_event(bus_event(KIND_STOP, 8'($urandom), 1'($urandom)));
                else if (pick == 8)
                    send_event(bus_event(KIND_ERROR + 3'($urandom_range(0, 3)),
                                         8'($urandom), 1'($urandom)));
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    send_event(bus_event(3'($urandom), 8'($urandom), 1'($urandom)));
            end
        end
    endtask

    // Result receiver: changing ready patterns, plus one long hold-off on request
    initial
    begin
        int          hold_left;
        int          window;
        int          cyc;
        ready_mode_t mode;
        res_ch.ready = 1'b0;
        hold_left    = 0;
        window       = 0;
        cyc          = 0;
        mode         = RDY_ALWAYS;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (window == 0)
            begin
                mode   = ready_mode_t'($urandom_range(0, 3));
                window = $urandom_range(20, 80);
            end
            window--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RDY_ALWAYS:   res_ch.ready <= 1'b1;
                    RDY_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_SPARSE:   res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:      res_ch.ready <= (cyc % 4 != 3);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.response, res_ch.released, res_ch.read_valid, res_ch.read_byte,
                   res_ch.dispatch, res_ch.dispatch_index, res_ch.dispatch_length};
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", NO_RESULT, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.response !== want.response || got.released !== want.released ||
                    got.read_valid !== want.read_valid || got.read_byte !== want.read_byte ||
                    got.dispatch !== want.dispatch ||
                    got.dispatch_index !== want.dispatch_index ||
                    got.dispatch_length !== want.dispatch_length)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // Watchdog: ends the run when no item moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
        $display("i2c_target_command_buffer_core regression: fail");
        $finish;
    end

    // Main sequence
    initial
    begin
        event_t     ev;
        int         ph;
        int         k;
        logic [7:0] dup_code;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        evt_ch.valid       = 1'b0;
        evt_ch.kind        = KIND_ADDR;
        evt_ch.data_byte   = '0;
        evt_ch.master_nack = 1'b0;
        hold_req           = 1'b0;
        burst_left         = 0;
        items_sent         = 0;
        mismatches         = 0;

        // shadow state at reset
        foreach (cmd_codes[i])
            cmd_codes[i] = '0;
        foreach (buf_mem[i])
            buf_mem[i] = '0;
        entries_used = '0;
        byte_cnt     = '0;
        rd_ptr       = '0;
        bus_busy     = 1'b0;
        cmd_matched  = 1'b0;
        cmd_idx      = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_table(8'h82, 8'h80, 8'h41, 8'h40, 3'd4);

        // Directed: reads on cleared buffer, match, restart dispatch, refusals,
        // error and other kinds, full buffer, read to the end of the buffer
        add_row(KIND_READ,    8'h00, 1'b0, 1,  1, outcome(RESP_ACK, 0, 1, 8'h00, 0, 0, 0));
        add_row(KIND_READ,    8'hFF, 1'b1, 1,  1, outcome(RESP_COMPLETE, 0, 0, 0, 0, 0, 0));
        add_row(KIND_STOP,    8'h00, 1'b0, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));
        add_row(KIND_ADDR,    8'h00, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'h41, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'h00, 1'b1, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'hFF, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_ADDR,    8'hFF, 1'b1, 1,  1, outcome(RESP_ACK, 0, 0, 0, 1, 2, 3));
        add_row(KIND_READ,    8'h00, 1'b1, 1,  1, outcome(RESP_ACK, 0, 1, 8'h41, 0, 0, 0));
        add_row(KIND_READ,    8'h00, 1'b0, 2,  0, NO_RESULT);
        add_row(KIND_READ,    8'h00, 1'b1, 1,  1, outcome(RESP_COMPLETE, 0, 0, 0, 0, 0, 0));
        add_row(KIND_STOP,    8'h00, 1'b0, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));
        add_row(KIND_ADDR,    8'h00, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'h13, 1'b0, 1,  1, outcome(RESP_NACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'h82, 1'b0, 1,  1, outcome(RESP_NACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_ERROR,   8'hAA, 1'b1, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));
        add_row(KIND_OTHER,   8'h55, 1'b0, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));
        add_row(KIND_SPARE_6, 8'h00, 1'b0, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));
        add_row(KIND_SPARE_7, 8'hFF, 1'b1, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));
        add_row(KIND_ADDR,    8'h00, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'h82, 1'b0, 16, 1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'h55, 1'b0, 1,  1, outcome(RESP_NACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_ERROR,   8'h00, 1'b0, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));
        add_row(KIND_STOP,    8'h00, 1'b0, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 1, 0, 16));
        add_row(KIND_ADDR,    8'h00, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_READ,    8'h00, 1'b0, 16, 0, NO_RESULT);
        add_row(KIND_READ,    8'h00, 1'b1, 1,  1, outcome(RESP_COMPLETE, 0, 0, 0, 0, 0, 0));
        add_row(KIND_READ,    8'h00, 1'b0, 1,  1, outcome(RESP_COMPLETE, 0, 0, 0, 0, 0, 0));
        add_row(KIND_WRITE,   8'h40, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 0, 0, 0));
        add_row(KIND_ADDR,    8'h00, 1'b0, 1,  1, outcome(RESP_ACK, 0, 0, 0, 1, 3, 1));
        add_row(KIND_STOP,    8'h00, 1'b0, 1,  1, outcome(RESP_COMPLETE, 1, 0, 0, 0, 0, 0));

        // repeated rows step the data byte
        foreach (directed_rows[i])
        begin
            for (k = 0; k < directed_rows[i].reps; k++)
            begin
                ev           = directed_rows[i].ev;
                ev.data_byte = ev.data_byte + 8'(k);
                send_event(ev, directed_rows[i].known, directed_rows[i].want);
            end
        end

        // Random phases, each with its own command table
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: load_table(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'd0);
                1: load_table(8'h00, 8'hFF, 8'($urandom), 8'($urandom), 3'd7);
                2:
                begin
                    // duplicate codes: the lower entry must win
                    dup_code = 8'($urandom);
                    load_table(dup_code, dup_code, 8'($urandom), 8'($urandom), 3'd2);
                end
                3: load_table(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'd1);
                4: load_table(8'hFF, 8'h00, 8'h7F, 8'h80, 3'd3);
                5: load_table(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'd5);
                default:
                    load_table(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'd6);
            endcase
            // long receiver hold-off while items keep coming
            if (ph == 1)
                hold_req = 1'b1;
            run_random(RAND_PER_PHASE);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch("result never arrived", expected_results[0], NO_RESULT);
            mismatches += expected_results.size() - 1;
        end
        if (mismatches == 0)
            $display("i2c_target_command_buffer_core regression: pass");
        else
            $display("i2c_target_command_buffer_core regression: fail");
        $finish;
    end

endmodule
